// ----- sv/button_click_gesture_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// Button click gesture decoder assertion macros
// Concurrent check macros shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_GESTURE_DECODER_DEFINES_SVH
`define BUTTON_CLICK_GESTURE_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BCGD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("bcgd assertion failed");
`define BCGD_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("bcgd assertion failed");
`else
`define BCGD_ASSERT(label, prop)
`define BCGD_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- sv/bcgd_pkg.sv -----
// ----------------------------------------------------------------------------
// Button click gesture decoder package
// Mode and event encodings, field widths and register reset values.
// ----------------------------------------------------------------------------
package bcgd_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [TimeW-1:0] DebounceReset = 32'd10;
    localparam logic [TimeW-1:0] DoubleWinReset = 32'd350;
    localparam logic [TimeW-1:0] LongStartReset = 32'd700;
    localparam logic [TimeW-1:0] LongRepeatReset = 32'd500;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_DEBOUNCE    = 2'd0,
        CFG_DOUBLE_WIN  = 2'd1,
        CFG_LONG_START  = 2'd2,
        CFG_LONG_REPEAT = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_DEBOUNCE = 3'd1,
        MODE_DECIDE   = 3'd2,
        MODE_SINGLE   = 3'd3,
        MODE_DOUBLE   = 3'd4,
        MODE_LONG     = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SINGLE = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_REPEAT = 3'd3,
        EV_STOP   = 3'd4
    } event_t;

    localparam logic [1:0] ClickTwo = 2'd2;
    localparam logic [1:0] ClickOne = 2'd1;
    localparam logic [1:0] ClickBad = 2'd3;

endpackage

// ----- sv/button_click_gesture_decoder.sv -----
// ----------------------------------------------------------------------------
// Button click gesture decoder
// Turns polled button levels with timestamps into click and long-press events.
// ----------------------------------------------------------------------------
// Each input beat is one poll of the button level with a free-running 32-bit
// tick count, and each poll produces exactly one output beat with an event code
// and the mode after that poll. The block takes one poll per clock cycle when
// the output is not held by m_tready, and its result passes through the input
// register and then the result register; the mode update between them is
// combinational, which sets that rate. Input ready follows output ready
// combinationally through the two registers. Configuration writes are expected
// only while no poll is in flight.
`include "button_click_gesture_decoder_defines.svh"

module button_click_gesture_decoder
    import bcgd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // pressed[0], now_time[32:1], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // event_code[2:0], mode_now[5:3], zero pad
    input  logic                 cfg_wr_en,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [TimeW-1:0]     cfg_wdata
);

    logic [TimeW-1:0] debounce_reg;
    logic [TimeW-1:0] double_win_reg;
    logic [TimeW-1:0] long_start_reg;
    logic [TimeW-1:0] long_repeat_reg;

    logic             in_valid_reg;
    logic             in_pressed_reg;
    logic [TimeW-1:0] in_now_reg;

    mode_t            mode_reg;
    mode_t            mode_next;
    logic [TimeW-1:0] last_time_reg;
    logic [TimeW-1:0] last_time_next;
    logic [1:0]       click_reg;
    logic [1:0]       click_next;
    event_t           event_next;

    logic             out_valid_reg;
    event_t           out_event_reg;
    mode_t            out_mode_reg;

    logic             advance;
    logic [TimeW-1:0] elapsed;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign elapsed  = in_now_reg - last_time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg    <= DebounceReset;
            double_win_reg  <= DoubleWinReset;
            long_start_reg  <= LongStartReset;
            long_repeat_reg <= LongRepeatReset;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE:    debounce_reg    <= cfg_wdata;
                CFG_DOUBLE_WIN:  double_win_reg  <= cfg_wdata;
                CFG_LONG_START:  long_start_reg  <= cfg_wdata;
                CFG_LONG_REPEAT: long_repeat_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pressed_reg <= s_tdata[0];
            in_now_reg     <= s_tdata[32:1];
        end
    end

    always_comb begin
        mode_next      = mode_reg;
        last_time_next = last_time_reg;
        click_next     = click_reg;
        case (mode_reg)
            MODE_IDLE: begin
                if (in_pressed_reg) begin
                    mode_next      = MODE_DEBOUNCE;
                    last_time_next = in_now_reg;
                end
                if (click_reg == ClickTwo) begin
                    mode_next = MODE_DOUBLE;
                end else if (click_reg == ClickOne && !in_pressed_reg
                             && elapsed > double_win_reg) begin
                    mode_next = MODE_SINGLE;
                end
            end
            MODE_DEBOUNCE: begin
                if (elapsed > debounce_reg) begin
                    if (in_pressed_reg) begin
                        mode_next      = MODE_DECIDE;
                        last_time_next = in_now_reg;
                    end else begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_DECIDE: begin
                if (in_pressed_reg) begin
                    if (elapsed > long_start_reg) begin
                        mode_next = MODE_LONG;
                    end
                end else begin
                    click_next     = click_reg + 2'd1;
                    mode_next      = MODE_IDLE;
                    last_time_next = in_now_reg;
                end
            end
            MODE_SINGLE, MODE_DOUBLE: begin
                click_next = 2'd0;
                mode_next  = MODE_IDLE;
            end
            MODE_LONG: begin
                if (in_pressed_reg) begin
                    if (elapsed > long_repeat_reg) begin
                        last_time_next = in_now_reg;
                    end
                end else begin
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        event_next = EV_NONE;
        case (mode_reg)
            MODE_SINGLE: event_next = EV_SINGLE;
            MODE_DOUBLE: event_next = EV_DOUBLE;
            MODE_LONG: begin
                if (!in_pressed_reg) begin
                    event_next = EV_STOP;
                end else if (elapsed > long_repeat_reg) begin
                    event_next = EV_REPEAT;
                end
            end
            default: event_next = EV_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            last_time_reg <= '0;
            click_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                mode_reg      <= mode_next;
                last_time_reg <= last_time_next;
                click_reg     <= click_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= event_next;
            out_mode_reg  <= mode_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_mode_reg, out_event_reg};

    `BCGD_ASSERT(a_stop_only_from_long,
        advance && event_next == EV_STOP |-> mode_reg == MODE_LONG)
    `BCGD_ASSERT(a_click_count_range,
        click_reg != ClickBad)
    `BCGD_ASSERT(a_state_holds_without_beat,
        !advance |=> $stable(mode_reg) && $stable(last_time_reg) && $stable(click_reg))
    `BCGD_ASSERT(a_input_held_while_blocked,
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_now_reg))
    `BCGD_ASSERT_ALWAYS(a_reset_clears_output,
        !aresetn |=> !m_tvalid)

endmodule
